### src/vpa_pkg.sv
// Package: sizes, codes and state type of the variable partition allocator.
package vpa_pkg;

   localparam int MAX_USED   = 16;
   localparam int MAX_FREE   = 32;
   localparam int ADDR_BITS  = 16;

   localparam int USED_IDX_W = $clog2(MAX_USED);
   localparam int FREE_IDX_W = $clog2(MAX_FREE);
   localparam int LEN_W      = 16;
   localparam int ID_W       = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [ID_W-1:0]  ID_MAX          = '1;
   localparam logic [1:0]       FIT_POLICY_RST  = 2'd0;
   localparam logic [LEN_W-1:0] TOTAL_SIZE_RST  = 16'd1024;
   localparam logic [LEN_W-1:0] MIN_FRAG_RST    = 16'd10;

   typedef enum logic [1:0] {
      REG_FIT_POLICY   = 2'd0,
      REG_TOTAL_SIZE   = 2'd1,
      REG_MIN_FRAGMENT = 2'd2
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_UNKNOWN_ID = 3'd2,
      ST_BAD_SIZE   = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_type;

   typedef enum logic [0:0] {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_CHECK,
      S_A_SCAN,
      S_A_DECIDE,
      S_C_SCAN,
      S_C_MOVE,
      S_A_GRANT,
      S_R_FIND,
      S_R_CHECK,
      S_R_SCAN,
      S_R_MERGE,
      S_OUT
   } state_type;

endpackage

### src/vpa_req_if.sv
// Request channel: valid/ready handshake with allocate/release payload.
interface vpa_req_if;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [vpa_pkg::LEN_W-1:0] alloc_units;
   logic [vpa_pkg::ID_W-1:0]  target_id;

   modport source (output valid, cmd, alloc_units, target_id, input ready);
   modport sink   (input valid, cmd, alloc_units, target_id, output ready);
endinterface

### src/vpa_rsp_if.sv
// Response channel: valid/ready handshake with allocator result payload.
interface vpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vpa_pkg::STATUS_W-1:0]  status;
   logic [vpa_pkg::ID_W-1:0]      region_id;
   logic [vpa_pkg::ADDR_BITS-1:0] start_address;
   logic [vpa_pkg::LEN_W-1:0]     granted_size;
   logic                          compacted;

   modport source (output valid, status, region_id, start_address, granted_size, compacted,
                   input ready);
   modport sink   (input valid, status, region_id, start_address, granted_size, compacted,
                   output ready);
endinterface

### src/variable_partition_allocator_unit.sv
// Top level: variable partition allocator with first/best/worst fit and compaction.
//
//   port group | dir | role
//   req_ch     | in  | allocate / release request, valid/ready
//   rsp_ch     | out | one result per request, valid/ready
//   csr_*      | in  | APB register port: fit_policy @0x0, total_size @0x4, min_fragment @0x8
//
// One request at a time through a scan sequencer with one table read per cycle.
// Allocate: check, free scan, decide, grant; compaction first adds used scans and moves.
// Release: used scan, check, free scan, merge. Result held until rsp_ch.ready.
// Synchronous reset: one free region [0,1024), no live regions, last id zero.
// Writing total_size empties the used table and leaves one free region [0,total_size) unless zero.
module variable_partition_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   vpa_req_if.sink                         req_ch,
   vpa_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [vpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [vpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import vpa_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]       fit_policy_ff;
   logic [LEN_W-1:0] total_size_ff;
   logic [LEN_W-1:0] min_frag_ff;

   logic [ADDR_BITS-1:0] free_start_ff [MAX_FREE];
   logic [LEN_W-1:0]     free_len_ff   [MAX_FREE];
   logic [MAX_FREE-1:0]  free_valid_ff;
   logic [ID_W-1:0]      used_id_ff    [MAX_USED];
   logic [ADDR_BITS-1:0] used_start_ff [MAX_USED];
   logic [LEN_W-1:0]     used_len_ff   [MAX_USED];
   logic [MAX_USED-1:0]  used_valid_ff;
   logic [MAX_USED-1:0]  moved_ff;
   logic [ID_W-1:0]      last_id_ff;

   logic [LEN_W-1:0]      size_ff;
   logic [ID_W-1:0]       tid_ff;
   logic [FREE_IDX_W-1:0] fidx_ff;
   logic [USED_IDX_W-1:0] uidx_ff;
   logic [USED_IDX_W-1:0] slot_ff;
   logic                  found_ff;
   logic [FREE_IDX_W-1:0] fpick_ff;
   logic [USED_IDX_W-1:0] upick_ff;
   logic [ADDR_BITS-1:0]  best_start_ff;
   logic [LEN_W-1:0]      best_len_ff;
   logic [LEN_W:0]        sum_ff;
   logic [LEN_W:0]        cursor_ff;
   logic                  comp_ff;
   logic [ADDR_BITS-1:0]  rs_ff;
   logic [LEN_W-1:0]      rl_ff;
   logic                  lo_ff, hi_ff;
   logic [FREE_IDX_W-1:0] lo_idx_ff, hi_idx_ff;
   logic [LEN_W-1:0]      lo_len_ff, hi_len_ff;

   logic [STATUS_W-1:0]  res_status_ff;
   logic [ID_W-1:0]      res_id_ff;
   logic [ADDR_BITS-1:0] res_start_ff;
   logic [LEN_W-1:0]     res_size_ff;
   logic                 res_comp_ff;

   logic                  cfg_wr;
   logic [1:0]            cfg_idx;
   logic                  req_xfer, rsp_xfer;
   logic                  used_free_ok;
   logic [USED_IDX_W-1:0] used_free_idx;
   logic                  free_slot_ok;
   logic [FREE_IDX_W-1:0] free_slot_idx;
   logic                  f_last, u_last;
   logic [ADDR_BITS-1:0]  cur_fs;
   logic [LEN_W-1:0]      cur_fl;
   logic                  cur_fv;
   logic [ADDR_BITS-1:0]  cur_us;
   logic [LEN_W-1:0]      cur_ul;
   logic [ID_W-1:0]       cur_uid;
   logic                  cur_uv;
   logic                  bad_size;
   logic                  fit_cand, fit_better;
   logic                  comp_cand;
   logic                  rel_match;
   logic [LEN_W:0]        rel_end;
   logic                  touch_lo, touch_hi;
   logic [LEN_W-1:0]      g_start, g_len, g_left;
   logic                  g_split;
   logic [ID_W-1:0]       new_id;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_index_type'(cfg_idx))
         REG_FIT_POLICY:   csr_prdata = {{(CSR_DATA_W-2){1'b0}}, fit_policy_ff};
         REG_TOTAL_SIZE:   csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, total_size_ff};
         REG_MIN_FRAGMENT: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, min_frag_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign req_xfer             = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = (state_ff == S_OUT);
   assign rsp_xfer             = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.status        = res_status_ff;
   assign rsp_ch.region_id     = res_id_ff;
   assign rsp_ch.start_address = res_start_ff;
   assign rsp_ch.granted_size  = res_size_ff;
   assign rsp_ch.compacted     = res_comp_ff;

   always_comb begin
      used_free_ok  = 1'b0;
      used_free_idx = '0;
      for (int i = MAX_USED-1; i >= 0; i--) begin
         if (!used_valid_ff[i]) begin
            used_free_ok  = 1'b1;
            used_free_idx = USED_IDX_W'(i);
         end
      end
      free_slot_ok  = 1'b0;
      free_slot_idx = '0;
      for (int i = MAX_FREE-1; i >= 0; i--) begin
         if (!free_valid_ff[i]) begin
            free_slot_ok  = 1'b1;
            free_slot_idx = FREE_IDX_W'(i);
         end
      end
   end

   assign f_last  = (fidx_ff == FREE_IDX_W'(MAX_FREE-1));
   assign u_last  = (uidx_ff == USED_IDX_W'(MAX_USED-1));
   assign cur_fs  = free_start_ff[fidx_ff];
   assign cur_fl  = free_len_ff[fidx_ff];
   assign cur_fv  = free_valid_ff[fidx_ff];
   assign cur_us  = used_start_ff[uidx_ff];
   assign cur_ul  = used_len_ff[uidx_ff];
   assign cur_uid = used_id_ff[uidx_ff];
   assign cur_uv  = used_valid_ff[uidx_ff];

   assign bad_size = (size_ff == '0) || (size_ff > total_size_ff);

   always_comb begin
      case (fit_type'(fit_policy_ff))
         FIT_BEST:  fit_better = (cur_fl < best_len_ff) ||
                                 (cur_fl == best_len_ff && cur_fs < best_start_ff);
         FIT_WORST: fit_better = (cur_fl > best_len_ff) ||
                                 (cur_fl == best_len_ff && cur_fs < best_start_ff);
         default:   fit_better = (cur_fs < best_start_ff);
      endcase
   end
   assign fit_cand  = cur_fv && (cur_fl >= size_ff) && (!found_ff || fit_better);
   assign comp_cand = cur_uv && !moved_ff[uidx_ff] && (!found_ff || cur_us < best_start_ff);
   assign rel_match = cur_uv && (cur_uid == tid_ff) && !found_ff;
   assign rel_end   = {1'b0, rs_ff} + {1'b0, rl_ff};
   assign touch_lo  = cur_fv && (({1'b0, cur_fs} + {1'b0, cur_fl}) == {1'b0, rs_ff});
   assign touch_hi  = cur_fv && !touch_lo && ({1'b0, cur_fs} == rel_end);

   assign g_start = free_start_ff[fpick_ff];
   assign g_len   = free_len_ff[fpick_ff];
   assign g_left  = g_len - size_ff;
   assign g_split = (g_left != '0) && (g_left >= min_frag_ff);
   assign new_id  = (last_id_ff == ID_MAX) ? ID_W'(1) : last_id_ff + ID_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = (req_ch.cmd == CMD_RELEASE) ? S_R_FIND : S_A_CHECK;
            end
         end
         S_A_CHECK: begin
            if (bad_size || !used_free_ok) begin
               state_in = S_OUT;
            end else begin
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            if (f_last) begin
               state_in = S_A_DECIDE;
            end
         end
         S_A_DECIDE: begin
            if (found_ff) begin
               state_in = S_A_GRANT;
            end else if (sum_ff < {1'b0, size_ff}) begin
               state_in = S_OUT;
            end else begin
               state_in = S_C_SCAN;
            end
         end
         S_C_SCAN: begin
            if (u_last) begin
               state_in = S_C_MOVE;
            end
         end
         S_C_MOVE: begin
            state_in = found_ff ? S_C_SCAN : S_A_GRANT;
         end
         S_A_GRANT: state_in = S_OUT;
         S_R_FIND: begin
            if (u_last) begin
               state_in = S_R_CHECK;
            end
         end
         S_R_CHECK: state_in = found_ff ? S_R_SCAN : S_OUT;
         S_R_SCAN: begin
            if (f_last) begin
               state_in = S_R_MERGE;
            end
         end
         S_R_MERGE: state_in = S_OUT;
         S_OUT: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff    <= FIT_POLICY_RST;
         total_size_ff    <= TOTAL_SIZE_RST;
         min_frag_ff      <= MIN_FRAG_RST;
         free_valid_ff    <= {{(MAX_FREE-1){1'b0}}, 1'b1};
         free_start_ff[0] <= '0;
         free_len_ff[0]   <= TOTAL_SIZE_RST;
         used_valid_ff    <= '0;
         last_id_ff       <= '0;
      end else begin
         if (cfg_wr) begin
            case (reg_index_type'(cfg_idx))
               REG_FIT_POLICY:   fit_policy_ff <= csr_pwdata[1:0];
               REG_TOTAL_SIZE: begin
                  total_size_ff    <= csr_pwdata[LEN_W-1:0];
                  free_valid_ff    <= {{(MAX_FREE-1){1'b0}}, (csr_pwdata[LEN_W-1:0] != '0)};
                  free_start_ff[0] <= '0;
                  free_len_ff[0]   <= csr_pwdata[LEN_W-1:0];
                  used_valid_ff    <= '0;
               end
               REG_MIN_FRAGMENT: min_frag_ff <= csr_pwdata[LEN_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  size_ff  <= req_ch.alloc_units;
                  tid_ff   <= req_ch.target_id;
                  fidx_ff  <= '0;
                  uidx_ff  <= '0;
                  found_ff <= 1'b0;
                  sum_ff   <= '0;
                  comp_ff  <= 1'b0;
                  lo_ff    <= 1'b0;
                  hi_ff    <= 1'b0;
               end
            end
            S_A_CHECK: begin
               slot_ff <= used_free_idx;
               if (bad_size || !used_free_ok) begin
                  res_status_ff <= bad_size ? ST_BAD_SIZE : ST_TABLE_FULL;
                  res_id_ff     <= '0;
                  res_start_ff  <= '0;
                  res_size_ff   <= '0;
                  res_comp_ff   <= 1'b0;
               end
            end
            S_A_SCAN: begin
               fidx_ff <= fidx_ff + FREE_IDX_W'(1);
               if (cur_fv) begin
                  sum_ff <= sum_ff + {1'b0, cur_fl};
               end
               if (fit_cand) begin
                  found_ff      <= 1'b1;
                  fpick_ff      <= fidx_ff;
                  best_len_ff   <= cur_fl;
                  best_start_ff <= cur_fs;
               end
            end
            S_A_DECIDE: begin
               if (!found_ff) begin
                  if (sum_ff < {1'b0, size_ff}) begin
                     res_status_ff <= ST_NO_SPACE;
                     res_id_ff     <= '0;
                     res_start_ff  <= '0;
                     res_size_ff   <= '0;
                     res_comp_ff   <= 1'b0;
                  end else begin
                     moved_ff  <= '0;
                     cursor_ff <= '0;
                     uidx_ff   <= '0;
                  end
               end
            end
            S_C_SCAN: begin
               uidx_ff <= uidx_ff + USED_IDX_W'(1);
               if (comp_cand) begin
                  found_ff      <= 1'b1;
                  upick_ff      <= uidx_ff;
                  best_start_ff <= cur_us;
                  best_len_ff   <= cur_ul;
               end
            end
            S_C_MOVE: begin
               uidx_ff <= '0;
               if (found_ff) begin
                  used_start_ff[upick_ff] <= cursor_ff[ADDR_BITS-1:0];
                  moved_ff[upick_ff]      <= 1'b1;
                  cursor_ff               <= cursor_ff + {1'b0, best_len_ff};
                  found_ff                <= 1'b0;
               end else begin
                  free_valid_ff    <= {{(MAX_FREE-1){1'b0}}, 1'b1};
                  free_start_ff[0] <= cursor_ff[ADDR_BITS-1:0];
                  free_len_ff[0]   <= sum_ff[LEN_W-1:0];
                  fpick_ff         <= '0;
                  comp_ff          <= 1'b1;
               end
            end
            S_A_GRANT: begin
               if (g_split) begin
                  free_start_ff[fpick_ff] <= g_start + size_ff;
                  free_len_ff[fpick_ff]   <= g_left;
                  used_len_ff[slot_ff]    <= size_ff;
                  res_size_ff             <= size_ff;
               end else begin
                  free_valid_ff[fpick_ff] <= 1'b0;
                  used_len_ff[slot_ff]    <= g_len;
                  res_size_ff             <= g_len;
               end
               last_id_ff             <= new_id;
               used_id_ff[slot_ff]    <= new_id;
               used_start_ff[slot_ff] <= g_start;
               used_valid_ff[slot_ff] <= 1'b1;
               res_status_ff          <= ST_OK;
               res_id_ff              <= new_id;
               res_start_ff           <= g_start;
               res_comp_ff            <= comp_ff;
            end
            S_R_FIND: begin
               uidx_ff <= uidx_ff + USED_IDX_W'(1);
               if (rel_match) begin
                  found_ff <= 1'b1;
                  upick_ff <= uidx_ff;
                  rs_ff    <= cur_us;
                  rl_ff    <= cur_ul;
               end
            end
            S_R_CHECK: begin
               fidx_ff <= '0;
               if (!found_ff) begin
                  res_status_ff <= ST_UNKNOWN_ID;
                  res_id_ff     <= '0;
                  res_start_ff  <= '0;
                  res_size_ff   <= '0;
                  res_comp_ff   <= 1'b0;
               end
            end
            S_R_SCAN: begin
               fidx_ff <= fidx_ff + FREE_IDX_W'(1);
               if (touch_lo) begin
                  lo_ff     <= 1'b1;
                  lo_idx_ff <= fidx_ff;
                  lo_len_ff <= cur_fl;
               end
               if (touch_hi) begin
                  hi_ff     <= 1'b1;
                  hi_idx_ff <= fidx_ff;
                  hi_len_ff <= cur_fl;
               end
            end
            S_R_MERGE: begin
               res_comp_ff <= 1'b0;
               if (lo_ff || hi_ff || free_slot_ok) begin
                  used_valid_ff[upick_ff] <= 1'b0;
                  res_status_ff           <= ST_OK;
                  res_id_ff               <= tid_ff;
                  res_start_ff            <= rs_ff;
                  res_size_ff             <= rl_ff;
               end else begin
                  res_status_ff <= ST_TABLE_FULL;
                  res_id_ff     <= '0;
                  res_start_ff  <= '0;
                  res_size_ff   <= '0;
               end
               if (lo_ff) begin
                  free_len_ff[lo_idx_ff] <= lo_len_ff + rl_ff + (hi_ff ? hi_len_ff : '0);
                  if (hi_ff) begin
                     free_valid_ff[hi_idx_ff] <= 1'b0;
                  end
               end else if (hi_ff) begin
                  free_start_ff[hi_idx_ff] <= rs_ff;
                  free_len_ff[hi_idx_ff]   <= hi_len_ff + rl_ff;
               end else if (free_slot_ok) begin
                  free_start_ff[free_slot_idx] <= rs_ff;
                  free_len_ff[free_slot_idx]   <= rl_ff;
                  free_valid_ff[free_slot_idx] <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
